/* src/motor_fader_position_control_defines.svh */
// Assertion macros for the fader controller checker.
`ifndef MOTOR_FADER_POSITION_CONTROL_DEFINES_SVH
`define MOTOR_FADER_POSITION_CONTROL_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MFPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MFPC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/mfpc_pkg.sv */
package mfpc_pkg;

  localparam int POS_W         = 10;
  localparam int TOUCH_W       = 16;
  localparam int TOL_W         = 9;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int POS_MAX       = 1023;
  localparam int DEFAULT_WINDOW = 16;
  localparam int QUEUE_DEPTH   = 4;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH_BASELINE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH_MARGIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SNAP_TOLERANCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_DEADBAND = 2'd3;

  // Register reset values
  localparam logic [TOUCH_W-1:0] RST_TOUCH_BASELINE = 16'd0;
  localparam logic [TOUCH_W-1:0] RST_TOUCH_MARGIN   = 16'd300;
  localparam logic [TOL_W-1:0]   RST_SNAP_TOLERANCE = 9'd8;
  localparam logic [POS_W-1:0]   RST_MOTOR_DEADBAND = 10'd50;

  typedef enum logic [1:0] {
    CMD_STOP = 2'd0,
    CMD_UP   = 2'd1,
    CMD_DOWN = 2'd2
  } motor_cmd_t;

  typedef struct packed {
    logic [TOUCH_W-1:0] touch_baseline;
    logic [TOUCH_W-1:0] touch_margin;
    logic [TOL_W-1:0]   snap_tolerance;
    logic [POS_W-1:0]   motor_deadband;
  } cfg_t;

endpackage

/* src/mfpc_queue.sv */
module mfpc_queue #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);
  import mfpc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [PW:0]      count;

  assign full      = (count == (PW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rptr];

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/mfpc_front.sv */
module mfpc_front #(
  parameter int WINDOW = mfpc_pkg::DEFAULT_WINDOW,
  parameter int SW     = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [mfpc_pkg::POS_W-1:0]   sample,
  input  logic [mfpc_pkg::TOUCH_W-1:0] touch_reading,
  input  mfpc_pkg::cfg_t               cfg,
  output logic [SW-1:0]                sum_next,
  output logic                         touched
);
  import mfpc_pkg::*;

  // Sample window as a delay line: tap 0 newest, last tap oldest
  logic [POS_W-1:0] window_line [WINDOW];
  logic [SW-1:0]    sample_sum;

  logic [TOUCH_W:0] touch_limit;

  // Running sum after this sample replaces the oldest one
  assign sum_next = sample_sum - SW'(window_line[WINDOW-1]) + SW'(sample);

  // Touch is a reading above baseline plus margin, compared without wrap
  assign touch_limit = {1'b0, cfg.touch_baseline} + {1'b0, cfg.touch_margin};
  assign touched     = ({1'b0, touch_reading} > touch_limit);

  // Shift the window and hold the sum
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        window_line[i] <= '0;
      end
    end else if (accept) begin
      sample_sum     <= sum_next;
      window_line[0] <= sample;
      for (int i = 1; i < WINDOW; i++) begin
        window_line[i] <= window_line[i-1];
      end
    end
  end

endmodule

/* src/mfpc_back.sv */
module mfpc_back #(
  parameter int WINDOW = mfpc_pkg::DEFAULT_WINDOW,
  parameter int SW     = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mfpc_pkg::cfg_t             cfg,
  input  logic                       q_valid,
  input  logic [SW-1:0]              q_sum,
  input  logic                       q_touched,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mfpc_pkg::POS_W-1:0] position,
  output logic                       touched,
  output logic                       human_moved,
  output mfpc_pkg::motor_cmd_t       motor_command
);
  import mfpc_pkg::*;

  // Divide by WINDOW as multiply by a rounded-up reciprocal, exact for all sums
  localparam int L    = $clog2(WINDOW);
  localparam int K    = SW + L;
  localparam int RW   = K + 1;
  localparam logic [RW-1:0] RECIP = RW'(((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic [SW+RW-1:0] product;
  logic [POS_W-1:0] avg_in;

  logic             a_valid;
  logic [POS_W-1:0] a_avg;
  logic             a_touched;

  logic             out_adv;
  logic             a_load;

  logic [POS_W-1:0] last_position;
  logic [POS_W-1:0] target_position;

  logic [POS_W:0]   avg_w;
  logic [POS_W:0]   tol_w;
  logic             near_low;
  logic             near_high;
  logic [POS_W-1:0] last_dist;
  logic [POS_W-1:0] pos_new;
  logic             human_new;
  logic [POS_W-1:0] target_new;
  logic [POS_W-1:0] target_dist;
  motor_cmd_t       cmd_new;

  assign product = q_sum * RECIP;
  assign avg_in  = product[K +: POS_W];

  assign out_adv = !out_valid || out_ready;
  assign a_load  = q_valid && (!a_valid || out_adv);
  assign q_pop   = a_load;

  // Snap to ends, hold near last position, then decide the motor command
  always_comb begin
    avg_w     = {1'b0, a_avg};
    tol_w     = {2'b00, cfg.snap_tolerance};
    near_low  = (avg_w < tol_w);
    near_high = ((avg_w + tol_w) > (POS_W+1)'(POS_MAX));
    last_dist = (a_avg >= last_position) ? (a_avg - last_position)
                                         : (last_position - a_avg);
    if (near_low) begin
      pos_new = '0;
    end else if (near_high) begin
      pos_new = POS_W'(POS_MAX);
    end else if (last_dist <= {1'b0, cfg.snap_tolerance}) begin
      pos_new = last_position;
    end else begin
      pos_new = a_avg;
    end
    human_new   = a_touched && (pos_new != last_position);
    target_new  = human_new ? pos_new : target_position;
    target_dist = (target_new >= pos_new) ? (target_new - pos_new)
                                          : (pos_new - target_new);
    if (human_new || (target_dist <= cfg.motor_deadband)) begin
      cmd_new = CMD_STOP;
    end else if (pos_new > target_new) begin
      cmd_new = CMD_DOWN;
    end else begin
      cmd_new = CMD_UP;
    end
  end

  // Average stage payload
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_avg     <= avg_in;
      a_touched <= q_touched;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (out_adv && a_valid) begin
      position      <= pos_new;
      touched       <= a_touched;
      human_moved   <= human_new;
      motor_command <= cmd_new;
    end
  end

  // Stage valids and position state
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid         <= 1'b0;
      out_valid       <= 1'b0;
      last_position   <= '0;
      target_position <= '0;
    end else begin
      a_valid <= a_load || (a_valid && !out_adv);
      if (out_adv) begin
        out_valid <= a_valid;
      end
      if (out_adv && a_valid) begin
        last_position   <= pos_new;
        target_position <= target_new;
      end
    end
  end

endmodule

/* src/motor_fader_position_control.sv */
// An accepted input beat passes through the queue, the average stage and the result register.
// Throughput: one beat per cycle unless stalled; a running window sum keeps each step short.
// A 4-entry queue between the sum front end and the filter/motor back end absorbs stalls.
// Reset (rst, synchronous) clears the sample window, sum, last and target positions,
// the queue and the pipeline, and loads the register defaults.
module motor_fader_position_control #(
  parameter int WINDOW = mfpc_pkg::DEFAULT_WINDOW
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [31:0]                    s_tdata,   // position_sample[9:0], touch_reading[25:10]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,   // position[9:0], touched[10],
                                                    // human_moved[11], motor_command[13:12]
  input  logic                           cfg_we,
  input  logic [mfpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mfpc_pkg::CFG_W-1:0]     cfg_data
);
  import mfpc_pkg::*;

  localparam int SW = $clog2(WINDOW * POS_MAX + 1);
  localparam int QW = SW + 1;

  cfg_t             cfg;
  logic             accept;
  logic [SW-1:0]    sum_next;
  logic             touch_hit;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic [QW-1:0]    q_head;
  logic [POS_W-1:0] position;
  logic             touched;
  logic             human_moved;
  motor_cmd_t       motor_command;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {2'b00, motor_command, human_moved, touched, position};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.touch_baseline <= RST_TOUCH_BASELINE;
      cfg.touch_margin   <= RST_TOUCH_MARGIN;
      cfg.snap_tolerance <= RST_SNAP_TOLERANCE;
      cfg.motor_deadband <= RST_MOTOR_DEADBAND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOUCH_BASELINE: cfg.touch_baseline <= cfg_data;
        REG_TOUCH_MARGIN:   cfg.touch_margin   <= cfg_data;
        REG_SNAP_TOLERANCE: cfg.snap_tolerance <= cfg_data[TOL_W-1:0];
        REG_MOTOR_DEADBAND: cfg.motor_deadband <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  mfpc_front #(
    .WINDOW (WINDOW),
    .SW     (SW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .sample        (s_tdata[POS_W-1:0]),
    .touch_reading (s_tdata[POS_W +: TOUCH_W]),
    .cfg           (cfg),
    .sum_next      (sum_next),
    .touched       (touch_hit)
  );

  mfpc_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data ({touch_hit, sum_next}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  mfpc_back #(
    .WINDOW (WINDOW),
    .SW     (SW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_sum         (q_head[SW-1:0]),
    .q_touched     (q_head[SW]),
    .q_pop         (q_pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .position      (position),
    .touched       (touched),
    .human_moved   (human_moved),
    .motor_command (motor_command)
  );

endmodule

/* src/mfpc_checker.sv */
`include "motor_fader_position_control_defines.svh"

module mfpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  import mfpc_pkg::*;

  // Stalled result holds
  `MFPC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
  // A touched move always stops the motor
  `MFPC_ASSERT(a_human_stop, m_tvalid && m_tdata[11] |-> m_tdata[10] && (m_tdata[13:12] == CMD_STOP), "human move without touch or stop")
  // Command never takes the unused code
  `MFPC_ASSERT(a_cmd_code, m_tvalid |-> (m_tdata[13:12] == CMD_STOP) || (m_tdata[13:12] == CMD_UP) || (m_tdata[13:12] == CMD_DOWN), "bad motor command")
  // Reset empties the pipeline and opens the input
  `MFPC_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid && s_tready, "pipeline not empty after reset")

endmodule

bind motor_fader_position_control mfpc_checker u_mfpc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* test/tb_motor_fader_position_control.sv */
module tb_motor_fader_position_control;
  timeunit 1ns;
  timeprecision 1ps;

  import mfpc_pkg::*;

  localparam int WINDOW      = DEFAULT_WINDOW;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 115;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [POS_W-1:0]   smp;
    logic [TOUCH_W-1:0] touch;
  } fader_in_t;

  typedef struct {
    logic [POS_W-1:0] pos;
    logic             touched;
    logic             human;
    motor_cmd_t       cmd;
  } fader_out_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;    // position_sample[9:0], touch_reading[25:10]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [15:0]          m_tdata;         // position[9:0], touched[10], human_moved[11],
                                         // motor_command[13:12]
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TOUCH_BASELINE;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Register shadow, tracks every write on the configuration port
  logic [TOUCH_W-1:0] touch_base = RST_TOUCH_BASELINE;
  logic [TOUCH_W-1:0] touch_marg = RST_TOUCH_MARGIN;
  logic [TOL_W-1:0]   snap_tol   = RST_SNAP_TOLERANCE;
  logic [POS_W-1:0]   deadband   = RST_MOTOR_DEADBAND;

  // Filter and motor state of the predictor
  logic [POS_W-1:0] win_ring [WINDOW] = '{default: '0};
  int               win_ptr = 0;
  logic [13:0]      win_sum = '0;
  logic [POS_W-1:0] held_pos = '0;
  logic [POS_W-1:0] goal_pos = '0;

  fader_in_t  pending_samples [$];
  fader_out_t expected_results [$];

  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  in_taken = 1'b0;
  int  cycle_count = 0;
  int  err_count = 0;
  int  n_accepted = 0;
  int  n_results = 0;
  int  n_touched = 0;
  int  n_human = 0;
  int  n_up = 0;
  int  n_down = 0;

  motor_fader_position_control i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Advance the moving average, snap/hold, then decide target and motor direction
  function automatic fader_out_t predict_fader(logic [POS_W-1:0] smp,
                                               logic [TOUCH_W-1:0] touch);
    fader_out_t r;
    int avg;
    int tol;
    r.touched = int'(touch) > int'(touch_base) + int'(touch_marg);
    win_sum = win_sum - win_ring[win_ptr] + smp;
    win_ring[win_ptr] = smp;
    win_ptr = (win_ptr + 1) % WINDOW;
    avg = int'(win_sum) / WINDOW;
    tol = int'(snap_tol);
    if (avg < tol) begin
      avg = 0;
    end else if (avg > POS_MAX - tol) begin
      avg = POS_MAX;
    end else if (gap(avg, int'(held_pos)) <= tol) begin
      avg = int'(held_pos);
    end
    r.pos = avg[POS_W-1:0];
    r.human = r.touched && (avg != int'(held_pos));
    if (r.human) begin
      goal_pos = avg[POS_W-1:0];
    end
    if (r.human || gap(int'(goal_pos), avg) <= int'(deadband)) begin
      r.cmd = CMD_STOP;
    end else if (avg > int'(goal_pos)) begin
      r.cmd = CMD_DOWN;
    end else begin
      r.cmd = CMD_UP;
    end
    held_pos = avg[POS_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      err_count++;
      if (err_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endfunction

  // Pick a touch reading on the requested side of the threshold, sometimes right at it
  function automatic logic [TOUCH_W-1:0] pick_touch(bit want);
    int thr;
    int v;
    thr = int'(touch_base) + int'(touch_marg);
    if (thr < 65535 && $urandom_range(7) == 0) begin
      v = thr + $urandom_range(1);
    end else if (want && thr < 65535) begin
      v = $urandom_range(65535, thr + 1);
    end else if (!want && thr < 65535) begin
      v = $urandom_range(thr, 0);
    end else begin
      v = $urandom_range(65535, 0);
    end
    return v[TOUCH_W-1:0];
  endfunction

  function automatic int pick_level();
    case ($urandom_range(3))
      0: return $urandom_range(20, 0);
      1: return $urandom_range(POS_MAX, POS_MAX - 20);
      default: return $urandom_range(POS_MAX, 0);
    endcase
  endfunction

  task automatic add_item(int smp, int touch);
    fader_in_t it;
    it.smp = smp[POS_W-1:0];
    it.touch = touch[TOUCH_W-1:0];
    pending_samples.push_back(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_TOUCH_BASELINE: touch_base = value[TOUCH_W-1:0];
      REG_TOUCH_MARGIN:   touch_marg = value[TOUCH_W-1:0];
      REG_SNAP_TOLERANCE: snap_tol = value[TOL_W-1:0];
      REG_MOTOR_DEADBAND: deadband = value[POS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(int base, int marg, int tol, int band);
    write_reg(REG_TOUCH_BASELINE, base[CFG_W-1:0]);
    write_reg(REG_TOUCH_MARGIN, marg[CFG_W-1:0]);
    write_reg(REG_SNAP_TOLERANCE, tol[CFG_W-1:0]);
    write_reg(REG_MOTOR_DEADBAND, band[CFG_W-1:0]);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || expected_results.size() != 0 || s_tvalid);
  endtask

  // Mostly operator gestures: slides and rests with steady touch, plus noise bursts
  task automatic queue_gestures(int n);
    int cnt;
    int len;
    int a;
    int b;
    int jit;
    int p;
    bit want;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(6, 1);
        repeat (len) add_item($urandom_range(POS_MAX, 0), $urandom_range(65535, 0));
      end else begin
        a = pick_level();
        b = ($urandom_range(2) == 0) ? a : pick_level();
        len = $urandom_range(40, 4);
        jit = $urandom_range(6, 0);
        want = $urandom_range(1);
        for (int i = 0; i < len; i++) begin
          // keep the slide arithmetic signed so downward slides step down
          p = a + ((b - a) * i) / len + int'($urandom_range(2 * jit, 0)) - jit;
          if (p < 0) p = 0;
          if (p > POS_MAX) p = POS_MAX;
          // flip the touch now and then to break the gesture
          add_item(p, pick_touch(($urandom_range(15) == 0) ? !want : want));
        end
      end
      cnt += len;
    end
  endtask

  // Present the next sample or idle; hold a beat until it is taken
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, pending_samples[0].touch, pending_samples[0].smp};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Check result beats against the oldest prediction, then record accepted input beats
  always @(posedge clk) begin : monitor
    fader_out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end else begin
      in_taken = 1'b0;
      if (!rst && m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("%0t: unexpected result beat, expected none, actual 0x%h",
                     $time, m_tdata);
          end
        end else begin
          want = expected_results.pop_front();
          check_field("position", want.pos, m_tdata[9:0]);
          check_field("touched", want.touched, m_tdata[10]);
          check_field("human_moved", want.human, m_tdata[11]);
          check_field("motor_command", want.cmd, m_tdata[13:12]);
          n_results++;
          if (want.touched) n_touched++;
          if (want.human) n_human++;
          if (want.cmd == CMD_UP) n_up++;
          if (want.cmd == CMD_DOWN) n_down++;
        end
      end
      if (!rst && s_tvalid && s_tready) begin
        in_taken = 1'b1;
        void'(pending_samples.pop_front());
        expected_results.push_back(predict_fader(s_tdata[9:0], s_tdata[25:10]));
        n_accepted++;
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed: window fills from zero towards full scale, touch at and around threshold
    add_item(POS_MAX, 0);
    add_item(POS_MAX, 65535);
    add_item(POS_MAX, 300);
    add_item(POS_MAX, 301);
    for (int i = 0; i < 12; i++) begin
      add_item(POS_MAX, (i % 3 == 0) ? 65535 : 0);
    end
    add_item(POS_MAX, 65535);
    add_item(0, 0);
    add_item(0, 0);
    add_item(0, 0);
    add_item(0, 0);
    add_item(0, 65535);
    add_item(512, 0);
    add_item(513, 12345);
    wait_drained();

    // Random phases: one register setting and one idle pattern each
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: write_all(0, 0, 0, 0);
        2: write_all(65535, 65535, 511, 1023);
        3: write_all(65535, 0, 0, 1023);
        4: write_all(0, 65535, 511, 0);
        5: write_all($urandom_range(40000, 0), $urandom_range(2000, 0),
                     $urandom_range(40, 0), $urandom_range(200, 0));
        6: write_all($urandom_range(1000, 0), $urandom_range(500, 0),
                     $urandom_range(12, 1), $urandom_range(60, 5));
        7: write_all($urandom_range(65535, 0), $urandom_range(65535, 0),
                     $urandom_range(65535, 0), $urandom_range(65535, 0));
        default: ;
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      queue_gestures(PHASE_ITEMS);
      wait_drained();
    end

    // Let any stray result beat show up before closing
    repeat (10) @(posedge clk);
    $display("Drove %0d samples over 8 register settings and 4 handshake patterns, %0d results.",
             n_accepted, n_results);
    $display("Touched %0d, operator moves %0d, motor up %0d, down %0d, mismatches %0d.",
             n_touched, n_human, n_up, n_down, err_count);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
